FILE: design/bmp_row_pixel_upscaler_top_assert.svh
// Assertion macros used by the upscaler row controller.
`ifndef BMP_ROW_PIXEL_UPSCALER_TOP_ASSERT_SVH
`define BMP_ROW_PIXEL_UPSCALER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define BMPUP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define BMPUP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bmpup_pkg.sv
// Types, codes and defaults shared by the upscaler modules.
package bmpup_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_SCALE_DEF = 16;

    localparam int SCALE_REG_W = 5;
    localparam int WIDTH_REG_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int PIX_W       = 6;
    localparam int RGB_W       = 24;

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_PAD    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } bmpup_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [1:0] kind;
        logic       row_end;
        logic       last;
    } bmpup_out_t;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic [1:0]       kind;
        logic [PIX_W-1:0] pix_cnt;
        logic [1:0]       pad_cnt;
        logic             row_done;
    } bmpup_job_t;

endpackage

FILE: design/bmp_row_pixel_upscaler_top.sv
// Top level of the nearest-neighbor BMP scanline upscaler.
// Pixel beats (op 0) are written to the line buffer and come out scale times, followed by
// zero pad beats at the end of each source row so the output row is a multiple of 4 bytes;
// tick beats (op 1) then replay the stored row scale-1 more times, one buffered pixel per
// tick. A pixel beat that arrives while replays are still owed is not stored and yields one
// reject beat. One item is in work at a time: a pixel beat yields scale pixels plus 0 to 3
// pad bytes, a tick adds a line-buffer read, and the output register passes one beat per
// cycle while m_ready allows. The next item is accepted as soon as the last result of the
// current one has moved into the output register. The line buffer needs no clearing after
// reset. Config writes take effect at once and belong in idle periods only.
module bmp_row_pixel_upscaler_top #(
    parameter int MAX_WIDTH = bmpup_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bmpup_pkg::MAX_SCALE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bmpup_pkg::bmpup_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bmpup_pkg::bmpup_out_t             m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [bmpup_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [bmpup_pkg::RGB_W-1:0]   wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [bmpup_pkg::RGB_W-1:0]   rd_data;
    logic                          job_valid;
    logic                          job_ready;
    bmpup_pkg::bmpup_job_t         job;

    bmpup_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE),
        .AW        (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    bmpup_lbuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_lbuf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bmpup_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: design/bmpup_lbuf.sv
// Line buffer: one write port, one read port with registered read data.
module bmpup_lbuf #(
    parameter int DEPTH = bmpup_pkg::MAX_WIDTH_DEF,
    parameter int AW    = 10
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [bmpup_pkg::RGB_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [bmpup_pkg::RGB_W-1:0]  rd_data
);

    logic [bmpup_pkg::RGB_W-1:0] mem [DEPTH];
    logic [bmpup_pkg::RGB_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bmpup_emit.sv
// Result serializer: expands one job into pixel and pad beats behind an output register.
module bmpup_emit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    input  bmpup_pkg::bmpup_job_t  job,
    output logic                   job_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bmpup_pkg::bmpup_out_t  m_data
);

    logic                             busy_reg, busy_next;
    logic [bmpup_pkg::RGB_W-1:0]      rgb_reg, rgb_next;
    logic [1:0]                       kind_reg, kind_next;
    logic [bmpup_pkg::PIX_W-1:0]      pix_left_reg, pix_left_next;
    logic [1:0]                       pad_left_reg, pad_left_next;
    logic                             row_done_reg, row_done_next;
    logic                             m_valid_reg, m_valid_next;
    bmpup_pkg::bmpup_out_t            m_data_reg, m_data_next;
    logic                             advance;
    logic                             final_beat;

    assign job_ready = !busy_reg;
    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign final_beat = (pix_left_reg == bmpup_pkg::PIX_W'(1) && pad_left_reg == 2'd0)
                     || (pix_left_reg == '0 && pad_left_reg == 2'd1);

    always_comb begin
        busy_next     = busy_reg;
        rgb_next      = rgb_reg;
        kind_next     = kind_reg;
        pix_left_next = pix_left_reg;
        pad_left_next = pad_left_reg;
        row_done_next = row_done_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (advance) begin
            m_valid_next = 1'b1;
            if (pix_left_reg != '0) begin
                m_data_next.out_blue  = rgb_reg[7:0];
                m_data_next.out_green = rgb_reg[15:8];
                m_data_next.out_red   = rgb_reg[23:16];
                m_data_next.kind      = kind_reg;
                pix_left_next         = pix_left_reg - bmpup_pkg::PIX_W'(1);
            end else begin
                m_data_next.out_blue  = 8'h00;
                m_data_next.out_green = 8'h00;
                m_data_next.out_red   = 8'h00;
                m_data_next.kind      = bmpup_pkg::KIND_PAD;
                pad_left_next         = pad_left_reg - 2'd1;
            end
            m_data_next.row_end = final_beat && row_done_reg;
            m_data_next.last    = final_beat;
            busy_next           = !final_beat;
        end else if (job_valid && !busy_reg) begin
            busy_next     = 1'b1;
            rgb_next      = job.rgb;
            kind_next     = job.kind;
            pix_left_next = job.pix_cnt;
            pad_left_next = job.pad_cnt;
            row_done_next = job.row_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        rgb_reg      <= rgb_next;
        kind_reg     <= kind_next;
        pix_left_reg <= pix_left_next;
        pad_left_reg <= pad_left_next;
        row_done_reg <= row_done_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: design/bmpup_ctrl.sv
// Row controller: config registers, write and replay positions, line-buffer access, job issue.
`include "bmp_row_pixel_upscaler_top_assert.svh"
module bmpup_ctrl #(
    parameter int MAX_WIDTH = bmpup_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bmpup_pkg::MAX_SCALE_DEF,
    parameter int AW        = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bmpup_pkg::bmpup_in_t              s_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [bmpup_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [bmpup_pkg::RGB_W-1:0]       wr_data,
    output logic                              rd_en,
    output logic [AW-1:0]                     rd_addr,
    input  logic [bmpup_pkg::RGB_W-1:0]       rd_data,
    output logic                              job_valid,
    output bmpup_pkg::bmpup_job_t             job,
    input  logic                              job_ready
);

    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int SCW = $clog2(MAX_SCALE + 1);

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    state_t                                state_reg, state_next;
    logic [bmpup_pkg::SCALE_REG_W-1:0]     scale_reg, scale_next;
    logic [bmpup_pkg::WIDTH_REG_W-1:0]     width_reg, width_next;
    logic [WCW-1:0]                        column_reg, column_next;
    logic [WCW-1:0]                        rcol_reg, rcol_next;
    logic [SCW-1:0]                        replays_reg, replays_next;

    logic [SCW-1:0]  scale_eff;
    logic [WCW-1:0]  width_eff;
    logic [31:0]     scale_ext;
    logic [31:0]     width_ext;
    logic [3:0]      ws_prod;
    logic [1:0]      ws_mod;
    logic [1:0]      pad_cnt;
    logic            accept;
    logic            col_done;
    logic            rcol_done;

    always_comb begin
        if (scale_reg == '0) begin
            scale_eff = SCW'(1);
        end else if (32'(scale_reg) > MAX_SCALE) begin
            scale_eff = SCW'(MAX_SCALE);
        end else begin
            scale_eff = SCW'(scale_reg);
        end
        if (width_reg == '0) begin
            width_eff = WCW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            width_eff = WCW'(MAX_WIDTH);
        end else begin
            width_eff = WCW'(width_reg);
        end
    end

    assign scale_ext = 32'(scale_eff);
    assign width_ext = 32'(width_eff);
    assign ws_prod   = {2'b00, width_ext[1:0]} * {2'b00, scale_ext[1:0]};
    assign ws_mod    = 2'(ws_prod[1:0] * 2'd3);
    assign pad_cnt   = 2'(2'd0 - ws_mod);

    assign col_done  = ({1'b0, column_reg} + (WCW+1)'(1)) >= {1'b0, width_eff};
    assign rcol_done = ({1'b0, rcol_reg} + (WCW+1)'(1)) >= {1'b0, width_eff};

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && job_ready;
    assign accept    = s_valid && s_ready;

    assign wr_addr = column_reg[AW-1:0];
    assign wr_data = {s_data.red, s_data.green, s_data.blue};
    assign rd_addr = rcol_reg[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        scale_next   = scale_reg;
        width_next   = width_reg;
        column_next  = column_reg;
        rcol_next    = rcol_reg;
        replays_next = replays_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        job_valid    = 1'b0;
        job          = '0;

        if (cfg_valid) begin
            if (cfg_index == bmpup_pkg::REG_SCALE) begin
                scale_next = cfg_data[bmpup_pkg::SCALE_REG_W-1:0];
            end else begin
                width_next = cfg_data[bmpup_pkg::WIDTH_REG_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.op == bmpup_pkg::OP_PIXEL) begin
                        job_valid = 1'b1;
                        if (replays_reg != '0) begin
                            job.kind    = bmpup_pkg::KIND_REJECT;
                            job.pix_cnt = bmpup_pkg::PIX_W'(1);
                        end else begin
                            wr_en        = 1'b1;
                            job.rgb      = wr_data;
                            job.kind     = bmpup_pkg::KIND_PIXEL;
                            job.pix_cnt  = bmpup_pkg::PIX_W'(scale_eff);
                            job.row_done = col_done;
                            job.pad_cnt  = col_done ? pad_cnt : 2'd0;
                            if (col_done) begin
                                column_next  = '0;
                                rcol_next    = '0;
                                replays_next = scale_eff - SCW'(1);
                            end else begin
                                column_next = column_reg + WCW'(1);
                            end
                        end
                    end else if (replays_reg != '0) begin
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                job_valid    = 1'b1;
                job.rgb      = rd_data;
                job.kind     = bmpup_pkg::KIND_PIXEL;
                job.pix_cnt  = bmpup_pkg::PIX_W'(scale_eff);
                job.row_done = rcol_done;
                job.pad_cnt  = rcol_done ? pad_cnt : 2'd0;
                if (rcol_done) begin
                    rcol_next    = '0;
                    replays_next = replays_reg - SCW'(1);
                end else begin
                    rcol_next = rcol_reg + WCW'(1);
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scale_reg   <= bmpup_pkg::SCALE_REG_W'(1);
            width_reg   <= bmpup_pkg::WIDTH_REG_W'(1);
            column_reg  <= '0;
            rcol_reg    <= '0;
            replays_reg <= '0;
        end else begin
            state_reg   <= state_next;
            scale_reg   <= scale_next;
            width_reg   <= width_next;
            column_reg  <= column_next;
            rcol_reg    <= rcol_next;
            replays_reg <= replays_next;
        end
    end

    `BMPUP_ASSERT_IMP(a_job_to_free_emitter, job_valid, job_ready, "job issued to busy emitter")
    `BMPUP_ASSERT_NXT(a_tick_yields_job, accept && s_data.op == bmpup_pkg::OP_TICK && replays_reg != '0, job_valid && job.kind == bmpup_pkg::KIND_PIXEL, "replay read gave no job")
    `BMPUP_ASSERT_NXT(a_reject_keeps_state, accept && s_data.op == bmpup_pkg::OP_PIXEL && replays_reg != '0, $stable(replays_reg) && $stable(column_reg) && $stable(rcol_reg), "rejected pixel changed state")
    `BMPUP_ASSERT_IMP(a_positions_in_range, 1'b1, 32'(column_reg) < MAX_WIDTH && 32'(rcol_reg) < MAX_WIDTH && 32'(replays_reg) < MAX_SCALE, "position out of range")

endmodule

FILE: tb/tb_bmp_row_pixel_upscaler_top.sv
// Testbench for the BMP scanline upscaler: scoreboard with predictor and randomized drivers.
`timescale 1ns / 1ps

module tb_bmp_row_pixel_upscaler_top;

    localparam int ROW_MAX   = 1024;
    localparam int ROW_AW    = $clog2(ROW_MAX);
    localparam int SCALE_MAX = 16;
    localparam int DRAIN     = 32;
    localparam int LIMIT     = 600000;

    class upscale_scoreboard;
        bmpup_pkg::bmpup_out_t pending[$];
        logic [23:0] row_store [ROW_MAX];
        logic [4:0]  scale_reg;
        logic [10:0] width_reg;
        int unsigned column;
        int unsigned replays_left;
        int unsigned replay_column;
        int unsigned high_water;
        int          errors;
        int          accepted;
        int          checked;
        int          pads;
        int          rejects;

        function new();
            scale_reg     = 5'd1;
            width_reg     = 11'd1;
            column        = 0;
            replays_left  = 0;
            replay_column = 0;
            high_water    = 0;
            errors        = 0;
            accepted      = 0;
            checked       = 0;
            pads          = 0;
            rejects       = 0;
        endfunction

        function int unsigned eff_scale();
            if (scale_reg == 0) return 1;
            if (scale_reg > SCALE_MAX) return SCALE_MAX;
            return scale_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > ROW_MAX) return ROW_MAX;
            return width_reg;
        endfunction

        function void set_reg(logic idx, logic [10:0] value);
            if (idx == bmpup_pkg::REG_SCALE) scale_reg = value[4:0];
            else width_reg = value;
        endfunction

        function void emit_pixel(logic [23:0] rgb, bit done);
            int unsigned s;
            int unsigned pad;
            int unsigned total;
            bmpup_pkg::bmpup_out_t beat;
            s     = eff_scale();
            pad   = done ? ((4 - ((eff_width() * s * 3) & 3)) & 3) : 0;
            total = s + pad;
            pads += pad;
            for (int unsigned k = 0; k < total; k++) begin
                beat = '0;
                if (k < s) begin
                    beat.out_blue  = rgb[7:0];
                    beat.out_green = rgb[15:8];
                    beat.out_red   = rgb[23:16];
                    beat.kind      = bmpup_pkg::KIND_PIXEL;
                end else begin
                    beat.kind = bmpup_pkg::KIND_PAD;
                end
                beat.row_end = done && (k == total - 1);
                beat.last    = (k == total - 1);
                pending.push_back(beat);
            end
        endfunction

        function void note_input(bmpup_pkg::bmpup_in_t it);
            logic [23:0] rgb;
            bit          done;
            bmpup_pkg::bmpup_out_t beat;
            accepted++;
            if (it.op == bmpup_pkg::OP_PIXEL) begin
                if (replays_left != 0) begin
                    beat      = '0;
                    beat.kind = bmpup_pkg::KIND_REJECT;
                    beat.last = 1'b1;
                    pending.push_back(beat);
                    rejects++;
                    return;
                end
                rgb = {it.red, it.green, it.blue};
                row_store[ROW_AW'(column)] = rgb;
                if (column + 1 > high_water) high_water = column + 1;
                done = (column + 1 >= eff_width());
                emit_pixel(rgb, done);
                if (done) begin
                    column        = 0;
                    replays_left  = eff_scale() - 1;
                    replay_column = 0;
                end else begin
                    column++;
                end
            end else if (replays_left != 0) begin
                rgb  = row_store[ROW_AW'(replay_column)];
                done = (replay_column + 1 >= eff_width());
                emit_pixel(rgb, done);
                if (done) begin
                    replay_column = 0;
                    replays_left--;
                end else begin
                    replay_column++;
                end
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s got %h want %h", checked, name, got, want));
        endtask

        task check_result(bmpup_pkg::bmpup_out_t got);
            bmpup_pkg::bmpup_out_t want;
            if (pending.size() == 0) begin
                report($sformatf("beat with nothing pending: %h", got));
                return;
            end
            want = pending.pop_front();
            check_field("out_blue", got.out_blue, want.out_blue);
            check_field("out_green", got.out_green, want.out_green);
            check_field("out_red", got.out_red, want.out_red);
            check_field("kind", {6'd0, got.kind}, {6'd0, want.kind});
            check_field("row_end", {7'd0, got.row_end}, {7'd0, want.row_end});
            check_field("last", {7'd0, got.last}, {7'd0, want.last});
            checked++;
        endtask
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    bmpup_pkg::bmpup_in_t              s_data;
    logic                              m_valid;
    logic                              m_ready;
    bmpup_pkg::bmpup_out_t             m_data;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic                              cfg_index;
    logic [bmpup_pkg::CFG_DATA_W-1:0]  cfg_data;

    upscale_scoreboard sb;
    int send_idle;
    int recv_stall;

    bmp_row_pixel_upscaler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin : watchdog
        int n;
        n = 0;
        while (n < LIMIT) begin
            @(posedge aclk);
            n++;
        end
        $display("timeout after %0d cycles", LIMIT);
        $display("tb_bmp_row_pixel_upscaler_top failed");
        $finish;
    end

    function automatic bmpup_pkg::bmpup_in_t make_item(logic op, logic [23:0] rgb);
        bmpup_pkg::bmpup_in_t it;
        it.op    = op;
        it.red   = rgb[23:16];
        it.green = rgb[15:8];
        it.blue  = rgb[7:0];
        return it;
    endfunction

    task automatic send_item(input bmpup_pkg::bmpup_in_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [10:0] pick_scale();
        int roll;
        logic [4:0] s;
        roll = $urandom_range(99);
        if (roll < 50) s = 5'($urandom_range(1, 4));
        else if (roll < 70) s = 5'($urandom_range(5, 15));
        else if (roll < 80) s = 5'd16;
        else if (roll < 90) s = 5'd0;
        else s = 5'($urandom_range(17, 31));
        return {6'($urandom), s};
    endfunction

    // keep replay reads inside the part of the row store already written
    function automatic logic [10:0] pick_width();
        int roll;
        if (sb.replays_left != 0) return 11'($urandom_range(1, sb.high_water));
        roll = $urandom_range(99);
        if (roll < 80) return 11'($urandom_range(1, 6));
        if (roll < 90) return 11'd0;
        return 11'($urandom_range(7, 24));
    endfunction

    task automatic run_traffic(input int target);
        int  sent;
        int  roll;
        bit  replaying;
        sent = 0;
        while (sent < target) begin
            roll      = $urandom_range(99);
            replaying = (sb.replays_left != 0);
            if (roll < 4) begin
                settle();
                if ($urandom_range(1)) write_reg(bmpup_pkg::REG_SCALE, pick_scale());
                else write_reg(bmpup_pkg::REG_WIDTH, pick_width());
            end else if (roll < 7) begin
                settle();
            end else if (replaying) begin
                send_item(make_item($urandom_range(99) < 90 ? bmpup_pkg::OP_TICK
                                                             : bmpup_pkg::OP_PIXEL,
                                    24'($urandom)));
                sent++;
            end else if ($urandom_range(99) < 8) begin
                send_item(make_item(bmpup_pkg::OP_TICK, 24'($urandom)));
            end else begin
                send_item(make_item(bmpup_pkg::OP_PIXEL, 24'($urandom)));
                sent++;
            end
        end
    endtask

    // finish the current row and its replays quickly by narrowing the row to one pixel
    task automatic flush_row();
        settle();
        write_reg(bmpup_pkg::REG_WIDTH, 11'd1);
        while (sb.replays_left != 0 || sb.column != 0)
            send_item(make_item(sb.replays_left != 0 ? bmpup_pkg::OP_TICK : bmpup_pkg::OP_PIXEL,
                                24'($urandom)));
        settle();
    endtask

    initial begin
        sb         = new();
        send_idle  = 0;
        recv_stall = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = bmpup_pkg::REG_SCALE;
        cfg_data   = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(make_item(bmpup_pkg::OP_TICK, 24'h123456));
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'h000000));
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'hffffff));
        settle();
        write_reg(bmpup_pkg::REG_SCALE, 11'd0);
        write_reg(bmpup_pkg::REG_WIDTH, 11'd0);
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'haa55c3));
        settle();
        write_reg(bmpup_pkg::REG_SCALE, 11'd3);
        write_reg(bmpup_pkg::REG_WIDTH, 11'd1);
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'h0f1e2d));
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'hffffff));
        send_item(make_item(bmpup_pkg::OP_TICK, 24'h000000));
        send_item(make_item(bmpup_pkg::OP_TICK, 24'hffffff));
        send_item(make_item(bmpup_pkg::OP_TICK, 24'h5a5a5a));
        settle();
        write_reg(bmpup_pkg::REG_SCALE, 11'd2);
        write_reg(bmpup_pkg::REG_WIDTH, 11'd1024);
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'h010203));
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'h808080));
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'hfe7f01));
        settle();
        write_reg(bmpup_pkg::REG_WIDTH, 11'd2);
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'h3c3c3c));
        send_item(make_item(bmpup_pkg::OP_TICK, 24'h000000));
        send_item(make_item(bmpup_pkg::OP_TICK, 24'h000000));
        settle();
        write_reg(bmpup_pkg::REG_SCALE, 11'd16);
        write_reg(bmpup_pkg::REG_WIDTH, 11'd1);
        send_item(make_item(bmpup_pkg::OP_PIXEL, 24'hc0ffee));
        send_item(make_item(bmpup_pkg::OP_TICK, 24'h000000));
        settle();
        write_reg(bmpup_pkg::REG_SCALE, 11'd5);
        send_item(make_item(bmpup_pkg::OP_TICK, 24'h000000));

        send_idle = 0;   recv_stall = 0;   run_traffic(38);
        send_idle = 68;  recv_stall = 0;   run_traffic(38);
        send_idle = 0;   recv_stall = 68;  run_traffic(38);
        send_idle = 6;   recv_stall = 6;   run_traffic(38);

        flush_row();
        write_reg(bmpup_pkg::REG_SCALE, 11'd1);
        write_reg(bmpup_pkg::REG_WIDTH, 11'd2047);
        for (int i = 0; i < 6; i++) send_item(make_item(bmpup_pkg::OP_PIXEL, 24'($urandom)));
        settle();

        $display("run covered %0d input beats and %0d checked result beats (%0d pad, %0d rejected)",
                 sb.accepted, sb.checked, sb.pads, sb.rejects);
        $display("across four pacing phases, clamped registers and the start of an over-wide row");
        if (sb.errors == 0) begin
            $display("tb_bmp_row_pixel_upscaler_top passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("tb_bmp_row_pixel_upscaler_top failed");
        end
        $finish;
    end
endmodule

FILE: bmp_row_pixel_upscaler_top.f
+incdir+design
design/bmpup_pkg.sv
design/bmpup_lbuf.sv
design/bmpup_emit.sv
design/bmpup_ctrl.sv
design/bmp_row_pixel_upscaler_top.sv
tb/tb_bmp_row_pixel_upscaler_top.sv
